>>> hdl/sha1_message_digest_defines.svh
// Assertion macros shared by the SHA-1 digest modules.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Check sampled on clk, switched off while rst is high.
`define SHA1MD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sha1md: check failed");

// Check sampled on clk, also active through reset.
`define SHA1MD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("sha1md: check failed");

`endif

>>> hdl/sha1md_pkg.sv
// Types, constants and helpers shared by the SHA-1 digest modules.
package sha1md_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        last;
  } item_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PACK  = 8'b0000_0010,
    S_PAD   = 8'b0000_0100,
    S_ZERO  = 8'b0000_1000,
    S_LEN   = 8'b0001_0000,
    S_ROUND = 8'b0010_0000,
    S_ADD   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  localparam logic [31:0] INIT_CHAIN [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [31:0] K_00_19 = 32'h5A82_7999;
  localparam logic [31:0] K_20_39 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_40_59 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_60_79 = 32'hCA62_C1D6;

  localparam logic [31:0] PAD_WORD      = 32'h8000_0000;
  localparam logic [2:0]  MAX_BYTES     = 3'd4;
  localparam logic [3:0]  LEN_HI_IDX    = 4'd14;
  localparam logic [3:0]  LEN_LO_IDX    = 4'd15;
  localparam logic [5:0]  LEN_BYTE_POS  = 6'd56;
  localparam logic [6:0]  LAST_ROUND    = 7'd79;
  localparam logic [2:0]  LAST_WORD_IDX = 3'd4;

  function automatic logic [31:0] byte_bits(input logic [3:0] m);
    byte_bits = {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
  endfunction

endpackage

>>> hdl/sha1_message_digest.sv
// Top level of the streaming SHA-1 digest block.
//
//   channel   direction  handshake            fields
//   message   in         push / full          message_word, byte_count, last_word
//   digest    out        pop / empty          digest_word, word_index, last_result
//
// A word whose bytes fit the current buffer word is packed in one step, two if it
// straddles a word boundary. Each completed 64-byte block stalls packing for the 80
// rounds of the single round unit and one chaining add. A last word adds padding and
// length, one or two compressions and five beats out.
// Reset is synchronous; no clearing pass. The queue keeps taking words while the back
// end compresses, and a finished digest beat waits in the output register for pop.
module sha1_message_digest #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] message_word,
  input  logic [2:0]  byte_count,
  input  logic        last_word,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_result
);
  import sha1md_pkg::*;

  item_t q_head;
  logic  q_empty;
  logic  q_pop;

  sha1md_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .message_word (message_word),
    .byte_count   (byte_count),
    .last_word    (last_word),
    .full         (full),
    .deq          (q_pop),
    .q_empty      (q_empty),
    .head         (q_head)
  );

  sha1md_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_result (last_result),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

>>> hdl/sha1md_front.sv
// Input side: byte count clamping, dropping of empty non-last words, short item queue.
`include "sha1_message_digest_defines.svh"

module sha1md_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [31:0]         message_word,
  input  logic [2:0]          byte_count,
  input  logic                last_word,
  output logic                full,
  input  logic                deq,
  output logic                q_empty,
  output sha1md_pkg::item_t   head
);
  import sha1md_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic [2:0]        cnt_clamped;
  logic              enq;

  assign cnt_clamped = (byte_count > MAX_BYTES) ? MAX_BYTES : byte_count;
  assign full        = (count == CNT_W'(DEPTH));
  assign q_empty     = (count == '0);
  assign enq         = push && !full && ((cnt_clamped != 3'd0) || last_word);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= '{word: message_word, cnt: cnt_clamped, last: last_word};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({enq, deq})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `SHA1MD_ASSERT(a_no_underflow, deq |-> !q_empty)
  `SHA1MD_ASSERT(a_head_count, !q_empty |-> head.cnt <= MAX_BYTES)
  `SHA1MD_ASSERT(a_fill_step, (enq && !deq) |=> count == $past(count) + CNT_W'(1))

endmodule

>>> hdl/sha1md_engine.sv
// Back end: block packing, padding, 80-round compression and digest output.
`include "sha1_message_digest_defines.svh"

module sha1md_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  sha1md_pkg::item_t q_head,
  output logic              q_pop,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index,
  output logic              last_result,
  output logic              empty,
  input  logic              pop
);
  import sha1md_pkg::*;

  state_t       state, state_next;
  state_t       ret, ret_next;
  logic [31:0]  wbuf [16];
  logic [5:0]   pos, pos_next;
  logic [63:0]  bit_length, bit_length_next;
  logic [6:0]   round;
  logic [31:0]  wa, wb, wc, wd, we;
  logic [31:0]  chain [5];
  logic [31:0]  hold_word, hold_word_next;
  logic [2:0]   hold_cnt, hold_cnt_next;
  logic         hold_last, hold_last_next;
  logic [2:0]   emit_idx;
  logic         out_valid;

  logic [31:0]  src_word;
  logic [2:0]   src_cnt;
  logic         src_last;
  logic [1:0]   off;
  logic [3:0]   idx;
  logic [2:0]   avail, take_n, rem;
  logic [3:0]   pack_bmask, pad_bmask;
  logic [31:0]  pack_bits, pad_bits;
  logic [31:0]  merged_pack, merged_pad;
  logic [6:0]   pos_sum;
  state_t       after_pack;
  logic         wr_en, len_wr, start_comp, chain_add, emit_load, msg_done;
  logic [31:0]  wr_data;
  logic [31:0]  sched_mix, sched_new;
  logic [31:0]  f_val, k_val, t_val;

  assign empty = !out_valid;
  assign q_pop = (state == S_IDLE) && !q_empty;

  // Byte packing and padding datapath
  always_comb begin
    src_word    = (state == S_IDLE) ? q_head.word : hold_word;
    src_cnt     = (state == S_IDLE) ? q_head.cnt  : hold_cnt;
    src_last    = (state == S_IDLE) ? q_head.last : hold_last;
    off         = pos[1:0];
    idx         = pos[5:2];
    avail       = MAX_BYTES - {1'b0, off};
    take_n      = (src_cnt < avail) ? src_cnt : avail;
    rem         = src_cnt - take_n;
    pack_bmask  = (~(4'b1111 >> take_n)) >> off;
    pad_bmask   = 4'b1111 >> off;
    pack_bits   = byte_bits(pack_bmask);
    pad_bits    = byte_bits(pad_bmask);
    merged_pack = (wbuf[idx] & ~pack_bits) | ((src_word >> {off, 3'b000}) & pack_bits);
    merged_pad  = (wbuf[idx] & ~pad_bits) | ((PAD_WORD >> {off, 3'b000}) & pad_bits);
    pos_sum     = {1'b0, pos} + {4'b0000, take_n};
    if (rem != 3'd0) begin
      after_pack = S_PACK;
    end else if (src_last) begin
      after_pack = S_PAD;
    end else begin
      after_pack = S_IDLE;
    end
  end

  // Round datapath
  always_comb begin
    sched_mix = wbuf[13] ^ wbuf[8] ^ wbuf[2] ^ wbuf[0];
    sched_new = {sched_mix[30:0], sched_mix[31]};
    if (round inside {[7'd0:7'd19]}) begin
      f_val = (wb & wc) | (~wb & wd);
      k_val = K_00_19;
    end else if (round inside {[7'd20:7'd39]}) begin
      f_val = wb ^ wc ^ wd;
      k_val = K_20_39;
    end else if (round inside {[7'd40:7'd59]}) begin
      f_val = (wb & wc) | (wb & wd) | (wc & wd);
      k_val = K_40_59;
    end else begin
      f_val = wb ^ wc ^ wd;
      k_val = K_60_79;
    end
    t_val = {wa[26:0], wa[31:27]} + f_val + we + k_val + wbuf[0];
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    ret_next        = ret;
    pos_next        = pos;
    bit_length_next = bit_length;
    hold_word_next  = hold_word;
    hold_cnt_next   = hold_cnt;
    hold_last_next  = hold_last;
    wr_en           = 1'b0;
    wr_data         = merged_pack;
    len_wr          = 1'b0;
    start_comp      = 1'b0;
    chain_add       = 1'b0;
    emit_load       = 1'b0;
    msg_done        = 1'b0;
    case (state)
      S_IDLE, S_PACK: begin
        if (state == S_PACK || !q_empty) begin
          if (state == S_IDLE) begin
            bit_length_next = bit_length + 64'({q_head.cnt, 3'b000});
          end
          wr_en          = 1'b1;
          pos_next       = pos_sum[5:0];
          hold_word_next = src_word << {take_n, 3'b000};
          hold_cnt_next  = rem;
          hold_last_next = src_last;
          if (pos_sum[6]) begin
            start_comp = 1'b1;
            ret_next   = after_pack;
            state_next = S_ROUND;
          end else begin
            state_next = after_pack;
          end
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        wr_data  = merged_pad;
        pos_next = {4'(idx + 4'd1), 2'b00};
        if (idx == LEN_LO_IDX) begin
          start_comp = 1'b1;
          ret_next   = S_ZERO;
          state_next = S_ROUND;
        end else begin
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (idx == LEN_HI_IDX) begin
          state_next = S_LEN;
        end else begin
          wr_en    = 1'b1;
          wr_data  = '0;
          pos_next = pos + 6'd4;
          if (idx == LEN_LO_IDX) begin
            start_comp = 1'b1;
            ret_next   = S_ZERO;
            state_next = S_ROUND;
          end
        end
      end
      S_LEN: begin
        len_wr     = 1'b1;
        pos_next   = '0;
        start_comp = 1'b1;
        ret_next   = S_EMIT;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        chain_add  = 1'b1;
        state_next = ret;
      end
      S_EMIT: begin
        if (!out_valid || pop) begin
          emit_load = 1'b1;
          if (emit_idx == LAST_WORD_IDX) begin
            msg_done        = 1'b1;
            bit_length_next = '0;
            pos_next        = '0;
            state_next      = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Block buffer doubles as the message schedule window
  always_ff @(posedge clk) begin
    if (state == S_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        wbuf[i] <= wbuf[i+1];
      end
      wbuf[15] <= sched_new;
    end else begin
      if (wr_en) begin
        wbuf[idx] <= wr_data;
      end
      if (len_wr) begin
        wbuf[LEN_HI_IDX] <= bit_length[63:32];
        wbuf[LEN_LO_IDX] <= bit_length[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_comp) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (state == S_ROUND) begin
      we <= wd;
      wd <= wc;
      wc <= {wb[1:0], wb[31:2]};
      wb <= wa;
      wa <= t_val;
    end
    hold_word <= hold_word_next;
    if (emit_load) begin
      digest_word <= chain[emit_idx];
      word_index  <= emit_idx;
      last_result <= (emit_idx == LAST_WORD_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      pos        <= '0;
      bit_length <= '0;
      round      <= '0;
      chain      <= INIT_CHAIN;
      hold_cnt   <= '0;
      hold_last  <= 1'b0;
      emit_idx   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      pos        <= pos_next;
      bit_length <= bit_length_next;
      hold_cnt   <= hold_cnt_next;
      hold_last  <= hold_last_next;
      if (start_comp) begin
        round <= '0;
      end else if (state == S_ROUND) begin
        round <= round + 7'd1;
      end
      if (chain_add) begin
        chain[0] <= chain[0] + wa;
        chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc;
        chain[3] <= chain[3] + wd;
        chain[4] <= chain[4] + we;
      end else if (msg_done) begin
        chain <= INIT_CHAIN;
      end
      if (emit_load) begin
        emit_idx <= (emit_idx == LAST_WORD_IDX) ? 3'd0 : emit_idx + 3'd1;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SHA1MD_ASSERT(a_round_end, state == S_ROUND && round == LAST_ROUND |=> state == S_ADD)
  `SHA1MD_ASSERT(a_len_slot, state == S_LEN |-> pos == LEN_BYTE_POS)
  `SHA1MD_ASSERT(a_msg_clear, msg_done |=> bit_length == 64'd0 && pos == 6'd0 && state == S_IDLE)
  `SHA1MD_ASSERT_ALWAYS(a_rst_idle, rst |=> state == S_IDLE && !out_valid)

endmodule
